/* rtl/core/bll_pkg.sv */
// Shared types and constants for the bounded linked list engine.
package bll_pkg;

   localparam int PoolDepth = 256;
   localparam int IdxW      = $clog2(PoolDepth);
   localparam int CntW      = $clog2(PoolDepth + 1);

   localparam logic [3:0] ActPushBack  = 4'd0;
   localparam logic [3:0] ActPushFront = 4'd1;
   localparam logic [3:0] ActPopBack   = 4'd2;
   localparam logic [3:0] ActPopFront  = 4'd3;
   localparam logic [3:0] ActInsert    = 4'd4;
   localparam logic [3:0] ActErase     = 4'd5;
   localparam logic [3:0] ActRead      = 4'd6;
   localparam logic [3:0] ActWrite     = 4'd7;
   localparam logic [3:0] ActClear     = 4'd8;

   localparam logic [1:0] StOk       = 2'd0;
   localparam logic [1:0] StFull     = 2'd1;
   localparam logic [1:0] StEmpty    = 2'd2;
   localparam logic [1:0] StBadPos   = 2'd3;

   typedef struct packed {
      logic [3:0]         action;
      logic [8:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [8:0]         list_size;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [1:0]         status;
   } rsp_type;

endpackage

/* rtl/core/bounded_linked_list_engine.sv */
// Linked list deque engine: node pool memories and the sequencer that walks them.
//
//   channel | ports                   | handshake
//   request | start, busy, req_data   | beat taken when start is high and busy low
//   result  | rsp_strobe, rsp_data    | one cycle per beat, receiver cannot stall
//
// Busy stays high after the accepted beat until the result is sent, and longer for
// each link walked from the front; positional actions walk position links, so the
// worst case is an insert at position 254. The single read port of each node memory,
// with its registered read data, sets the pace of the walk. The result strobe rises
// as busy falls. Reset empties the list; node memories are not cleared.
module bounded_linked_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bll_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bll_pkg::rsp_type rsp_data
);

   localparam int IW = bll_pkg::IdxW;
   localparam int CW = bll_pkg::CntW;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DECIDE = 5'd1;
   localparam logic [4:0] S_GRAB   = 5'd2;
   localparam logic [4:0] S_GRAB_W = 5'd3;
   localparam logic [4:0] S_PLACE  = 5'd4;
   localparam logic [4:0] S_WALK   = 5'd5;
   localparam logic [4:0] S_WALK_W = 5'd6;
   localparam logic [4:0] S_DISP   = 5'd7;
   localparam logic [4:0] S_MID_W  = 5'd8;
   localparam logic [4:0] S_MID_B  = 5'd9;
   localparam logic [4:0] S_TAKE_W = 5'd10;
   localparam logic [4:0] S_REL    = 5'd11;
   localparam logic [4:0] S_ACC_W  = 5'd12;
   localparam logic [4:0] S_FIN    = 5'd13;
   localparam logic [4:0] S_FIN_W  = 5'd14;
   localparam logic [4:0] S_BACK_W = 5'd15;
   localparam logic [4:0] S_MID_RD = 5'd16;
   localparam logic [4:0] S_TAKE   = 5'd17;
   localparam logic [4:0] S_ACC    = 5'd18;

   logic [31:0] val_mem [bll_pkg::PoolDepth];
   logic [IW-1:0] fwd_mem [bll_pkg::PoolDepth];
   logic [IW-1:0] bwd_mem [bll_pkg::PoolDepth];

   logic          val_we, fwd_we, bwd_we;
   logic [IW-1:0] val_wa, fwd_wa, bwd_wa, val_ra, fwd_ra, bwd_ra;
   logic [IW-1:0] fwd_wd, bwd_wd;
   logic [31:0]   val_wd;
   logic [31:0]   val_rd_ff;
   logic [IW-1:0] fwd_rd_ff, bwd_rd_ff;

   logic [4:0]    state_ff, state_in;
   logic [3:0]    act_ff, act_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [31:0]   v_ff, v_in;
   logic [IW-1:0] node_ff, node_in, new_ff, new_in;
   logic [CW-1:0] step_ff, step_in;
   logic [IW-1:0] first_ff, first_in, last_ff, last_in, fhead_ff, fhead_in;
   logic [CW-1:0] count_ff, count_in, fresh_ff, fresh_in, fcount_ff, fcount_in;
   logic [31:0]   rd_ff, rd_in, front_ff, front_in;
   logic [1:0]    status_ff, status_in;
   logic          strobe_ff, strobe_in;
   bll_pkg::rsp_type rsp_ff, rsp_in;
   logic [CW-1:0] step_nx;

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= val_wd;
      if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
      if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
      val_rd_ff <= val_mem[val_ra];
      fwd_rd_ff <= fwd_mem[fwd_ra];
      bwd_rd_ff <= bwd_mem[bwd_ra];
   end

   assign step_nx = step_ff + CW'(1);

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      pos_in    = pos_ff;
      v_in      = v_ff;
      node_in   = node_ff;
      new_in    = new_ff;
      step_in   = step_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      fhead_in  = fhead_ff;
      count_in  = count_ff;
      fresh_in  = fresh_ff;
      fcount_in = fcount_ff;
      rd_in     = rd_ff;
      front_in  = front_ff;
      status_in = status_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      val_we = 1'b0; fwd_we = 1'b0; bwd_we = 1'b0;
      val_wa = new_ff; fwd_wa = new_ff; bwd_wa = new_ff;
      val_wd = v_ff; fwd_wd = node_ff; bwd_wd = node_ff;
      val_ra = node_ff; fwd_ra = node_ff; bwd_ra = node_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in    = req_data.action;
               pos_in    = req_data.position;
               v_in      = req_data.value;
               rd_in     = '0;
               status_in = bll_pkg::StOk;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            node_in  = first_ff;
            step_in  = '0;
            state_in = S_FIN;
            case (act_ff)
               bll_pkg::ActPushBack, bll_pkg::ActPushFront, bll_pkg::ActInsert: begin
                  if (count_ff == CW'(bll_pkg::PoolDepth)) begin
                     status_in = bll_pkg::StFull;
                  end else if (act_ff == bll_pkg::ActInsert && pos_ff > count_ff) begin
                     status_in = bll_pkg::StBadPos;
                  end else begin
                     if (act_ff == bll_pkg::ActPushBack) pos_in = count_ff;
                     else if (act_ff == bll_pkg::ActPushFront) pos_in = '0;
                     state_in = S_GRAB;
                  end
               end
               bll_pkg::ActPopBack, bll_pkg::ActPopFront: begin
                  if (count_ff == '0) begin
                     status_in = bll_pkg::StEmpty;
                  end else begin
                     node_in  = (act_ff == bll_pkg::ActPopBack) ? last_ff : first_ff;
                     state_in = S_TAKE;
                  end
               end
               bll_pkg::ActErase, bll_pkg::ActRead, bll_pkg::ActWrite: begin
                  if (pos_ff >= count_ff) status_in = bll_pkg::StBadPos;
                  else if (pos_ff == '0) state_in = S_DISP;
                  else state_in = S_WALK;
               end
               bll_pkg::ActClear: begin
                  count_in  = '0;
                  fresh_in  = '0;
                  fhead_in  = '0;
                  fcount_in = '0;
                  first_in  = '0;
                  last_in   = '0;
               end
               default: ;
            endcase
         end
         S_GRAB: begin
            fwd_ra   = fhead_ff;
            state_in = S_GRAB_W;
         end
         S_GRAB_W: begin
            if (fcount_ff != '0) begin
               new_in    = fhead_ff;
               fhead_in  = fwd_rd_ff;
               fcount_in = fcount_ff - CW'(1);
            end else begin
               new_in   = fresh_ff[IW-1:0];
               fresh_in = fresh_ff + CW'(1);
            end
            state_in = S_PLACE;
         end
         S_PLACE: begin
            val_we   = 1'b1;
            state_in = S_FIN;
            if (count_ff == '0) begin
               first_in = new_ff;
               last_in  = new_ff;
               count_in = count_ff + CW'(1);
            end else if (pos_ff == '0) begin
               fwd_we = 1'b1; fwd_wd = first_ff;
               bwd_we = 1'b1; bwd_wa = first_ff; bwd_wd = new_ff;
               first_in = new_ff;
               count_in = count_ff + CW'(1);
            end else if (pos_ff >= count_ff) begin
               bwd_we = 1'b1; bwd_wd = last_ff;
               fwd_we = 1'b1; fwd_wa = last_ff; fwd_wd = new_ff;
               last_in  = new_ff;
               count_in = count_ff + CW'(1);
            end else begin
               node_in  = first_ff;
               step_in  = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            state_in = S_WALK_W;
         end
         S_WALK_W: begin
            node_in  = fwd_rd_ff;
            step_in  = step_nx;
            state_in = (step_nx == pos_ff) ? S_DISP : S_WALK;
         end
         S_DISP: begin
            case (act_ff)
               bll_pkg::ActErase: state_in = S_TAKE;
               bll_pkg::ActRead:  state_in = S_ACC;
               bll_pkg::ActWrite: begin
                  val_we   = 1'b1;
                  val_wa   = node_ff;
                  state_in = S_FIN;
               end
               default: state_in = S_MID_RD;
            endcase
         end
         S_MID_RD: begin
            state_in = S_MID_W;
         end
         S_MID_W: begin
            // The new node sits between the walked node and its predecessor.
            fwd_we = 1'b1; fwd_wd = node_ff;
            bwd_we = 1'b1; bwd_wd = bwd_rd_ff;
            step_in  = CW'(bwd_rd_ff);
            state_in = S_MID_B;
         end
         S_MID_B: begin
            fwd_we = 1'b1; fwd_wa = step_ff[IW-1:0]; fwd_wd = new_ff;
            bwd_we = 1'b1; bwd_wa = node_ff; bwd_wd = new_ff;
            count_in = count_ff + CW'(1);
            state_in = S_FIN;
         end
         S_TAKE: begin
            state_in = S_TAKE_W;
         end
         S_TAKE_W: begin
            rd_in = val_rd_ff;
            if (count_ff > CW'(1)) begin
               if (node_ff == first_ff) begin
                  first_in = fwd_rd_ff;
               end else if (node_ff == last_ff) begin
                  last_in = bwd_rd_ff;
               end else begin
                  fwd_we = 1'b1; fwd_wa = bwd_rd_ff; fwd_wd = fwd_rd_ff;
                  bwd_we = 1'b1; bwd_wa = fwd_rd_ff; bwd_wd = bwd_rd_ff;
               end
            end
            state_in = S_REL;
         end
         S_REL: begin
            fwd_we = 1'b1; fwd_wa = node_ff; fwd_wd = fhead_ff;
            fhead_in  = node_ff;
            fcount_in = fcount_ff + CW'(1);
            count_in  = count_ff - CW'(1);
            state_in  = S_FIN;
         end
         S_ACC: begin
            state_in = S_ACC_W;
         end
         S_ACC_W: begin
            rd_in    = val_rd_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            val_ra = first_ff;
            if (count_ff == '0) begin
               rsp_in.read_value  = rd_ff;
               rsp_in.list_size   = count_ff;
               rsp_in.front_value = -32'sd1;
               rsp_in.back_value  = -32'sd1;
               rsp_in.status      = status_ff;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_FIN_W;
            end
         end
         S_FIN_W: begin
            val_ra   = last_ff;
            front_in = val_rd_ff;
            state_in = S_BACK_W;
         end
         S_BACK_W: begin
            rsp_in.read_value  = rd_ff;
            rsp_in.list_size   = count_ff;
            rsp_in.front_value = front_ff;
            rsp_in.back_value  = val_rd_ff;
            rsp_in.status      = status_ff;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         first_ff  <= '0;
         last_ff   <= '0;
         count_ff  <= '0;
         fresh_ff  <= '0;
         fhead_ff  <= '0;
         fcount_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         fresh_ff  <= fresh_in;
         fhead_ff  <= fhead_in;
         fcount_ff <= fcount_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      pos_ff    <= pos_in;
      v_ff      <= v_in;
      node_ff   <= node_in;
      new_ff    <= new_in;
      step_ff   <= step_in;
      rd_ff     <= rd_in;
      front_ff  <= front_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
